>>> hw/rtl/fsps_pkg.sv
// ----------------------------------------------------------------------------
// fsps_pkg: shared types, constants and microcode for the sand step unit
// Grid geometry, item field layout, control word layout and the control
// program that sequences the datapath.
// ----------------------------------------------------------------------------
package fsps_pkg;

  localparam int unsigned GRID_W    = 128;
  localparam int unsigned GRID_H    = 128;
  localparam int unsigned X_W       = $clog2(GRID_W);
  localparam int unsigned Y_W       = $clog2(GRID_H);
  localparam int unsigned ADDR_W    = X_W + Y_W;
  localparam int unsigned CELLS     = GRID_W * GRID_H;
  localparam int unsigned DIM_W     = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 16;

  localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(GRID_W);
  localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(GRID_H);

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PLACE  = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_EOF    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAND  = 2'd0,
    KIND_WATER = 2'd1,
    KIND_SMOKE = 2'd2,
    KIND_SOLID = 2'd3
  } kind_e;

  // Step codes of the control program
  typedef logic [3:0] step_t;
  localparam step_t ST_IDLE  = 4'd0;
  localparam step_t ST_PLACE = 4'd1;
  localparam step_t ST_U0    = 4'd2;
  localparam step_t ST_U1    = 4'd3;
  localparam step_t ST_U2    = 4'd4;
  localparam step_t ST_U3    = 4'd5;
  localparam step_t ST_U4    = 4'd6;
  localparam step_t ST_U5    = 4'd7;
  localparam step_t ST_U6    = 4'd8;
  localparam step_t ST_SW0   = 4'd9;
  localparam step_t ST_SW1   = 4'd10;
  localparam step_t ST_EMIT  = 4'd11;
  localparam step_t ST_CLR   = 4'd12;

  // Read address source
  typedef enum logic [2:0] {
    RD_SWEEP, RD_VERT, RD_LS, RD_RS, RD_LD, RD_RD
  } rd_e;

  // Which empty flag latches the data of the previous step's read
  typedef enum logic [2:0] {
    CAP_NONE, CAP_V, CAP_LS, CAP_RS, CAP_LD, CAP_RD
  } cap_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_PLACE, WR_MOVE, WR_SWEEP, WR_CLEAR
  } wr_e;

  typedef enum logic [2:0] {
    J_NEXT,      // step + 1
    J_GOTO,      // target
    J_DISPATCH,  // wait for an item, branch on its mode
    J_LOOP,      // repeat until the sweep counter wraps, then target
    J_EMIT       // wait for the output register, then target
  } jmp_e;

  typedef struct packed {
    rd_e   rd;
    cap_e  cap;
    wr_e   wr;
    jmp_e  jmp;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '{rd: RD_SWEEP, cap: CAP_NONE, wr: WR_NONE, jmp: J_GOTO, target: ST_IDLE};
    unique case (s)
      ST_IDLE:  w = '{RD_SWEEP, CAP_NONE, WR_NONE,  J_DISPATCH, ST_IDLE};
      ST_PLACE: w = '{RD_SWEEP, CAP_NONE, WR_PLACE, J_GOTO,     ST_EMIT};
      ST_U0:    w = '{RD_VERT,  CAP_NONE, WR_NONE,  J_NEXT,     ST_IDLE};
      ST_U1:    w = '{RD_LS,    CAP_V,    WR_NONE,  J_NEXT,     ST_IDLE};
      ST_U2:    w = '{RD_RS,    CAP_LS,   WR_NONE,  J_NEXT,     ST_IDLE};
      ST_U3:    w = '{RD_LD,    CAP_RS,   WR_NONE,  J_NEXT,     ST_IDLE};
      ST_U4:    w = '{RD_RD,    CAP_LD,   WR_NONE,  J_NEXT,     ST_IDLE};
      ST_U5:    w = '{RD_SWEEP, CAP_RD,   WR_NONE,  J_NEXT,     ST_IDLE};
      ST_U6:    w = '{RD_SWEEP, CAP_NONE, WR_MOVE,  J_GOTO,     ST_EMIT};
      ST_SW0:   w = '{RD_SWEEP, CAP_NONE, WR_SWEEP, J_LOOP,     ST_SW1};
      ST_SW1:   w = '{RD_SWEEP, CAP_NONE, WR_NONE,  J_GOTO,     ST_EMIT};
      ST_EMIT:  w = '{RD_SWEEP, CAP_NONE, WR_NONE,  J_EMIT,     ST_IDLE};
      ST_CLR:   w = '{RD_SWEEP, CAP_NONE, WR_CLEAR, J_LOOP,     ST_IDLE};
      default:  w = '{RD_SWEEP, CAP_NONE, WR_NONE,  J_GOTO,     ST_IDLE};
    endcase
    return w;
  endfunction

  // Register value to usable dimension: 0 reads as 1, clamp at the grid size
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v,
                                               logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/falling_sand_particle_step_unit.sv
// ----------------------------------------------------------------------------
// falling_sand_particle_step_unit: one particle move of a sand automaton
// Two occupancy bitmaps (prior frame, frame being built) in RAM; a small
// control program reads the neighbor cells, picks the move and marks it.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake            | Payload
//  s_      | in  | s_tvalid_i/s_tready_o | tuser: mode; tdata: x, y, kind, pick
//  m_      | out | m_tvalid_o/m_tready_i | tdata: new_x, new_y, moved
//  cfg_    | in  | cfg_valid_i/cfg_ready_o | index, data (width, height)
//
//  Update: 5 neighbor reads through the shared RAM read address, then
//  decide and write, then emit. Place: write, then emit; mode 3 and an
//  item outside the active area: emit only.
//  End of frame: one cell per cycle over the whole grid, then emit.
//  After reset a clearing pass over all CELLS cells runs; s_tready_o stays low.
//  A held result does not block the next item; only its emit step waits.
// ----------------------------------------------------------------------------
module falling_sand_particle_step_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  // [6:0] cell_x, [13:7] cell_y, [15:14] kind, [16] pick_left, rest zero
  input  logic [fsps_pkg::S_TDATA_W-1:0]      s_tdata_i,
  // [1:0] mode
  input  logic [fsps_pkg::MODE_W-1:0]         s_tuser_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  // [6:0] new_x, [13:7] new_y, [14] moved, rest zero
  output logic [fsps_pkg::M_TDATA_W-1:0]      m_tdata_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fsps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fsps_pkg::DIM_W-1:0]          cfg_data_i
);
  import fsps_pkg::*;

  // Control
  step_t             step_q, step_d;
  ucode_t            uc;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              accept;
  logic              out_free;

  // Configuration
  logic [DIM_W-1:0]  eff_w_q, eff_h_q;

  // Item fields
  mode_e             in_mode;
  logic [X_W-1:0]    in_x;
  logic [Y_W-1:0]    in_y;
  logic              in_range;
  logic [X_W-1:0]    x_q;
  logic [Y_W-1:0]    y_q;
  kind_e             kind_q;
  logic              pick_q;

  // Neighbor flags (1 = cell empty in both frames)
  logic              e_v_q, e_ls_q, e_rs_q, e_ld_q, e_rd_q;
  logic              rd_empty;

  // Move decision
  logic [X_W-1:0]    xl, xr, nx;
  logic [Y_W-1:0]    ty, ny;
  logic              can_l, can_r, vert_ok, lf_d, rf_d, lf_s, rf_s, moved;

  // Result
  logic [X_W-1:0]    res_x_q;
  logic [Y_W-1:0]    res_y_q;
  logic              res_moved_q;
  logic              out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;

  // RAM ports
  logic [ADDR_W-1:0] raddr;
  logic              prior_we, next_we;
  logic [ADDR_W-1:0] prior_waddr, next_waddr;
  logic              prior_wdata, next_wdata;
  logic              prior_rdata, next_rdata;
  logic              copy_v_q;
  logic [ADDR_W-1:0] copy_addr_q;

  assign uc         = ucode_rom(step_q);
  assign s_tready_o = (uc.jmp == J_DISPATCH);
  assign accept     = s_tvalid_i && s_tready_o;
  assign out_free   = !out_valid_q || m_tready_i;
  assign cfg_ready_o = 1'b1;

  assign in_mode  = mode_e'(s_tuser_i);
  assign in_x     = s_tdata_i[X_W-1:0];
  assign in_y     = s_tdata_i[X_W+Y_W-1:X_W];
  assign in_range = ({1'b0, in_x} < eff_w_q) && ({1'b0, in_y} < eff_h_q);

  // Next step
  always_comb begin
    step_d = step_q;
    unique case (uc.jmp)
      J_NEXT: step_d = step_q + step_t'(1);
      J_GOTO: step_d = uc.target;
      J_DISPATCH: begin
        if (accept) begin
          unique case (in_mode)
            MODE_PLACE:  step_d = in_range ? ST_PLACE : ST_EMIT;
            MODE_UPDATE: step_d = in_range ? ST_U0 : ST_EMIT;
            MODE_EOF:    step_d = ST_SW0;
            MODE_NONE:   step_d = ST_EMIT;
          endcase
        end
      end
      J_LOOP: begin
        if (cnt_q == '1) begin
          step_d = uc.target;
        end
      end
      J_EMIT: begin
        if (out_free) begin
          step_d = uc.target;
        end
      end
      default: step_d = step_q;
    endcase
  end

  assign cnt_d = (uc.jmp == J_LOOP) ? cnt_q + ADDR_W'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_CLR;
      cnt_q  <= '0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= DIM_MAX_W;
      eff_h_q <= DIM_MAX_H;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_ACTIVE_WIDTH) begin
        eff_w_q <= eff_dim(cfg_data_i, DIM_MAX_W);
      end else if (cfg_index_i == CFG_ACTIVE_HEIGHT) begin
        eff_h_q <= eff_dim(cfg_data_i, DIM_MAX_H);
      end
    end
  end

  // Neighbor coordinates; wrapped values are masked by the edge checks
  assign xl = x_q - X_W'(1);
  assign xr = x_q + X_W'(1);
  assign ty = (kind_q == KIND_SMOKE) ? y_q - Y_W'(1) : y_q + Y_W'(1);

  always_comb begin
    raddr = cnt_q;
    unique case (uc.rd)
      RD_SWEEP: raddr = cnt_q;
      RD_VERT:  raddr = {x_q, ty};
      RD_LS:    raddr = {xl, y_q};
      RD_RS:    raddr = {xr, y_q};
      RD_LD:    raddr = {xl, ty};
      RD_RD:    raddr = {xr, ty};
      default:  raddr = cnt_q;
    endcase
  end

  assign rd_empty = !(prior_rdata || next_rdata);

  always_ff @(posedge clk_i) begin
    unique case (uc.cap)
      CAP_V:   e_v_q  <= rd_empty;
      CAP_LS:  e_ls_q <= rd_empty;
      CAP_RS:  e_rs_q <= rd_empty;
      CAP_LD:  e_ld_q <= rd_empty;
      CAP_RD:  e_rd_q <= rd_empty;
      default: ;
    endcase
  end

  // Move decision
  assign can_l   = (x_q != '0);
  assign can_r   = ({1'b0, x_q} + DIM_W'(1)) < eff_w_q;
  assign vert_ok = (kind_q == KIND_SMOKE) ? (y_q != '0)
                                          : (({1'b0, y_q} + DIM_W'(1)) < eff_h_q);
  assign lf_d    = can_l && e_ld_q && e_ls_q;
  assign rf_d    = can_r && e_rd_q && e_rs_q;
  assign lf_s    = can_l && e_ls_q;
  assign rf_s    = can_r && e_rs_q;

  always_comb begin
    nx = x_q;
    ny = y_q;
    priority if (vert_ok && e_v_q) begin
      ny = ty;
    end else if (kind_q != KIND_SOLID && vert_ok && (lf_d || rf_d)) begin
      ny = ty;
      nx = (lf_d && (!rf_d || pick_q)) ? xl : xr;
    end else if (kind_q == KIND_WATER && (lf_s || rf_s)) begin
      nx = (lf_s && (!rf_s || pick_q)) ? xl : xr;
    end else begin
      nx = x_q;
    end
  end

  assign moved = (nx != x_q) || (ny != y_q);

  // Item capture and result build
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= in_x;
      y_q    <= in_y;
      kind_q <= kind_e'(s_tdata_i[X_W+Y_W+KIND_W-1:X_W+Y_W]);
      pick_q <= s_tdata_i[X_W+Y_W+KIND_W];
      if (in_mode == MODE_PLACE || in_mode == MODE_UPDATE) begin
        res_x_q <= in_x;
        res_y_q <= in_y;
      end else begin
        res_x_q <= '0;
        res_y_q <= '0;
      end
      res_moved_q <= 1'b0;
    end else if (uc.wr == WR_MOVE) begin
      res_x_q     <= nx;
      res_y_q     <= ny;
      res_moved_q <= moved;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uc.jmp == J_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.jmp == J_EMIT && out_free) begin
      out_data_q <= M_TDATA_W'({res_moved_q, res_y_q, res_x_q});
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  // Frame sweep: next is read and cleared, prior takes the data in the following cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_v_q <= 1'b0;
    end else begin
      copy_v_q <= (uc.wr == WR_SWEEP);
    end
  end

  always_ff @(posedge clk_i) begin
    copy_addr_q <= cnt_q;
  end

  assign prior_we    = (uc.wr == WR_CLEAR) || copy_v_q;
  assign prior_waddr = copy_v_q ? copy_addr_q : cnt_q;
  assign prior_wdata = copy_v_q && next_rdata;

  always_comb begin
    next_we    = 1'b0;
    next_waddr = cnt_q;
    next_wdata = 1'b0;
    unique case (uc.wr)
      WR_NONE: next_we = 1'b0;
      WR_PLACE: begin
        next_we    = 1'b1;
        next_waddr = {x_q, y_q};
        next_wdata = 1'b1;
      end
      WR_MOVE: begin
        next_we    = 1'b1;
        next_waddr = {nx, ny};
        next_wdata = 1'b1;
      end
      WR_SWEEP, WR_CLEAR: begin
        next_we    = 1'b1;
        next_waddr = cnt_q;
        next_wdata = 1'b0;
      end
      default: next_we = 1'b0;
    endcase
  end

  fsps_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_prior_ram (
    .clk_i   (clk_i),
    .we_i    (prior_we),
    .waddr_i (prior_waddr),
    .wdata_i (prior_wdata),
    .raddr_i (raddr),
    .rdata_o (prior_rdata)
  );

  fsps_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (raddr),
    .rdata_o (next_rdata)
  );

endmodule

>>> hw/rtl/fsps_ram.sv
// ----------------------------------------------------------------------------
// fsps_ram: generic simple dual-port RAM
// One write port, one read port, read data registered. No reset on contents.
// ----------------------------------------------------------------------------
module fsps_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents when the same address is written
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/fsps_checker.sv
// ----------------------------------------------------------------------------
// fsps_checker: port-level checks for the sand step unit
// Watches the stream and output handshakes; bound to the top level below.
// ----------------------------------------------------------------------------
module fsps_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_o,
  input  logic [fsps_pkg::MODE_W-1:0]    s_tuser_i,
  input  logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  input  logic [fsps_pkg::M_TDATA_W-1:0] m_tdata_o
);
  import fsps_pkg::*;

  // A held result stays put until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("output item changed while stalled");

  // Each accepted item keeps the unit busy, so two items are never taken back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input taken on consecutive cycles");

  // A new result only appears out of a busy step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(!s_tready_o))
    else $error("result appeared without work in flight");

  // Mode 3 gives an all-zero result, through the emit step, when the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o && s_tuser_i == MODE_NONE && !m_tvalid_o
      |-> ##2 m_tvalid_o && m_tdata_o == '0)
    else $error("mode 3 result wrong or late");

endmodule

bind falling_sand_particle_step_unit fsps_checker u_fsps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tuser_i  (s_tuser_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for falling_sand_particle_step_unit
// Drives place, update, end-of-frame and unused items over the input stream.
// A local occupancy model predicts every move, and results are checked in
// order. Grid sizes are changed between frames, both stream sides idle at
// random, and one long output stall backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsps_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_INDEX = 8'hFF;

  typedef struct {
    logic [X_W-1:0] nx;
    logic [Y_W-1:0] ny;
    logic           moved;
  } move_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [MODE_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  // model state
  bit               prior_occ [CELLS];
  bit               next_occ  [CELLS];
  logic [DIM_W-1:0] width_reg  = DIM_W'(GRID_W);
  logic [DIM_W-1:0] height_reg = DIM_W'(GRID_H);
  move_t            expected_moves [$];

  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  bit hold_req  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  int items_sent = 0;
  int moves_checked = 0;
  int sweeps = 0;
  int reg_writes = 0;
  int frame_no = 0;
  int mismatches = 0;

  falling_sand_particle_step_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),   // [6:0] x, [13:7] y, [15:14] kind, [16] pick_left
    .s_tuser_i   (s_tuser),   // [1:0] mode
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),   // [6:0] new_x, [13:7] new_y, [14] moved
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic int usable_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    return (v > maxv) ? int'(maxv) : int'(v);
  endfunction

  function automatic bit cell_free(int x, int y);
    return !prior_occ[x * GRID_H + y] && !next_occ[x * GRID_H + y];
  endfunction

  // Column of a sideways or diagonal move, -1 if neither side is open
  function automatic int side_target(int x, int y, int dy, int w, bit pick);
    int  ty;
    bit  lf;
    bit  rf;
    ty = y + dy;
    lf = (x > 0) && (dy == 0 || cell_free(x - 1, ty)) && cell_free(x - 1, y);
    rf = (x + 1 < w) && (dy == 0 || cell_free(x + 1, ty)) && cell_free(x + 1, y);
    if (lf && rf) return pick ? x - 1 : x + 1;
    if (lf) return x - 1;
    if (rf) return x + 1;
    return -1;
  endfunction

  function automatic move_t step_particle(mode_e mode, int x, int y, kind_e kind,
                                          bit pick);
    move_t r;
    int    w;
    int    h;
    int    nx;
    int    ny;
    int    sx;
    bit    done;
    r = '{nx: '0, ny: '0, moved: 1'b0};
    w = usable_dim(width_reg, GRID_W);
    h = usable_dim(height_reg, GRID_H);
    nx = x;
    ny = y;
    done = 1'b0;
    if (mode == MODE_EOF) begin
      for (int i = 0; i < CELLS; i++) begin
        prior_occ[i] = next_occ[i];
        next_occ[i] = 1'b0;
      end
      return r;
    end
    if (mode == MODE_NONE) return r;
    r.nx = X_W'(x);
    r.ny = Y_W'(y);
    if (x >= w || y >= h) return r;
    if (mode == MODE_PLACE) begin
      next_occ[x * GRID_H + y] = 1'b1;
      return r;
    end
    case (kind)
      KIND_SAND, KIND_WATER: begin
        if (y + 1 < h) begin
          sx = cell_free(x, y + 1) ? x : side_target(x, y, 1, w, pick);
          if (sx >= 0) begin
            nx = sx;
            ny = y + 1;
            done = 1'b1;
          end
        end
        if (!done && kind == KIND_WATER) begin
          sx = side_target(x, y, 0, w, pick);
          if (sx >= 0) nx = sx;
        end
      end
      KIND_SMOKE: begin
        if (y > 0) begin
          sx = cell_free(x, y - 1) ? x : side_target(x, y, -1, w, pick);
          if (sx >= 0) begin
            nx = sx;
            ny = y - 1;
          end
        end
      end
      default: begin
        if (y + 1 < h && cell_free(x, y + 1)) ny = y + 1;
      end
    endcase
    next_occ[nx * GRID_H + ny] = 1'b1;
    r.nx = X_W'(nx);
    r.ny = Y_W'(ny);
    r.moved = (nx != x) || (ny != y);
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Called and returning at a falling edge; leaves tvalid high afterwards
  task automatic offer_item(mode_e mode, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                            kind_e kind, bit pick);
    while (sender_idles && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'd0, pick, kind, y, x};
    forever begin
      @(posedge clk_i);
      if (s_tready) break;
    end
    expected_moves.push_back(step_particle(mode, int'(x), int'(y), kind, pick));
    items_sent++;
    if (mode == MODE_EOF) sweeps++;
    @(negedge clk_i);
  endtask

  // Drop the input and wait until every result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_moves.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready) break;
    end
    if (index == CFG_ACTIVE_WIDTH) width_reg = data;
    else if (index == CFG_ACTIVE_HEIGHT) height_reg = data;
    reg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_grid(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    drain_results();
    write_reg(CFG_ACTIVE_WIDTH, w);
    write_reg(CFG_ACTIVE_HEIGHT, h);
  endtask

  // One frame: places and updates in a small window, some noise, then sweep
  task automatic run_frame(int n);
    int w;
    int h;
    int winx;
    int winy;
    int bx;
    int by;
    int r;
    w = usable_dim(width_reg, GRID_W);
    h = usable_dim(height_reg, GRID_H);
    winx = (w < 8) ? w : 8;
    winy = (h < 8) ? h : 8;
    case ($urandom_range(0, 2))
      0: begin bx = 0; by = 0; end
      1: begin bx = w - winx; by = h - winy; end
      default: begin
        bx = $urandom_range(0, w - winx);
        by = $urandom_range(0, h - winy);
      end
    endcase
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        offer_item(MODE_PLACE, X_W'(bx + $urandom_range(0, winx - 1)),
                   Y_W'(by + $urandom_range(0, winy - 1)),
                   kind_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (r < 85) begin
        offer_item(MODE_UPDATE, X_W'(bx + $urandom_range(0, winx - 1)),
                   Y_W'(by + $urandom_range(0, winy - 1)),
                   kind_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (r < 92) begin
        offer_item(MODE_UPDATE, X_W'($urandom), Y_W'($urandom),
                   kind_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (r < 96) begin
        offer_item(MODE_NONE, X_W'($urandom), Y_W'($urandom),
                   kind_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else begin
        offer_item(MODE_PLACE, X_W'($urandom), Y_W'($urandom),
                   kind_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
    offer_item(MODE_EOF, X_W'($urandom), Y_W'($urandom),
               kind_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    frame_no++;
  endtask

  // ---------------------------------------------------------------- receiver

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !receiver_idles || ($urandom_range(0, 99) >= 30);
    end
  end

  always @(posedge clk_i) begin
    move_t want;
    move_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{nx: m_tdata[6:0], ny: m_tdata[13:7], moved: m_tdata[14]};
      if (expected_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result x=%0d y=%0d moved=%0b", $realtime,
                   got.nx, got.ny, got.moved);
      end else begin
        want = expected_moves.pop_front();
        moves_checked++;
        if (got.nx !== want.nx || got.ny !== want.ny || got.moved !== want.moved)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d: expected x=%0d y=%0d moved=%0b, got x=%0d y=%0d moved=%0b",
                     $realtime, moves_checked, want.nx, want.ny, want.moved,
                     got.nx, got.ny, got.moved);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_moves();
    offer_item(MODE_PLACE,  7'd5,   7'd6,   KIND_SAND,  1'b0);
    offer_item(MODE_UPDATE, 7'd5,   7'd5,   KIND_SAND,  1'b1);  // blocked below, both diagonals open
    offer_item(MODE_UPDATE, 7'd5,   7'd5,   KIND_SAND,  1'b0);
    offer_item(MODE_UPDATE, 7'd127, 7'd127, KIND_WATER, 1'b0);  // bottom right corner
    offer_item(MODE_UPDATE, 7'd0,   7'd127, KIND_WATER, 1'b1);
    offer_item(MODE_UPDATE, 7'd0,   7'd0,   KIND_SMOKE, 1'b1);  // top row, stays
    offer_item(MODE_UPDATE, 7'd64,  7'd10,  KIND_SMOKE, 1'b0);
    offer_item(MODE_PLACE,  7'd70,  7'd9,   KIND_SMOKE, 1'b0);
    offer_item(MODE_UPDATE, 7'd70,  7'd10,  KIND_SMOKE, 1'b0);
    offer_item(MODE_UPDATE, 7'd127, 7'd0,   KIND_SOLID, 1'b1);
    offer_item(MODE_UPDATE, 7'd10,  7'd127, KIND_SOLID, 1'b0);
    offer_item(MODE_PLACE,  7'd20,  7'd21,  KIND_SOLID, 1'b0);
    offer_item(MODE_UPDATE, 7'd20,  7'd20,  KIND_SOLID, 1'b1);
    offer_item(MODE_NONE,   7'd127, 7'd127, KIND_SOLID, 1'b1);
    offer_item(MODE_EOF,    7'd127, 7'd127, KIND_SOLID, 1'b1);
    // now blocked by the prior frame only
    offer_item(MODE_UPDATE, 7'd5,   7'd5,   KIND_SAND,  1'b1);
  endtask

  task automatic test_dimension_limits();
    set_grid(8'd0, 8'd255);            // reads as 1 x 128
    write_reg(CFG_BAD_INDEX, 8'h55);
    offer_item(MODE_UPDATE, 7'd0,   7'd50,  KIND_WATER, 1'b1);
    offer_item(MODE_UPDATE, 7'd1,   7'd50,  KIND_SAND,  1'b0);  // outside the area
    offer_item(MODE_PLACE,  7'd127, 7'd127, KIND_SAND,  1'b0);
    set_grid(8'd200, 8'd1);
    offer_item(MODE_UPDATE, 7'd3,   7'd0,   KIND_WATER, 1'b0);
    offer_item(MODE_UPDATE, 7'd3,   7'd0,   KIND_SMOKE, 1'b1);
    offer_item(MODE_UPDATE, 7'd3,   7'd1,   KIND_SAND,  1'b1);
    offer_item(MODE_EOF,    7'd0,   7'd0,   KIND_SAND,  1'b0);
  endtask

  task automatic test_random_frames(int target);
    logic [DIM_W-1:0] ws [8] = '{8'd8, 8'd5, 8'd128, 8'd1, 8'd128, 8'd2, 8'd3, 8'd255};
    logic [DIM_W-1:0] hs [8] = '{8'd8, 8'd12, 8'd128, 8'd128, 8'd1, 8'd2, 8'd40, 8'd255};
    while (items_sent < target) begin
      if (frame_no < 8) set_grid(ws[frame_no], hs[frame_no]);
      else if ($urandom_range(0, 1))
        set_grid(DIM_W'($urandom_range(1, 12)), DIM_W'($urandom_range(1, 12)));
      else set_grid(DIM_W'($urandom), DIM_W'($urandom));
      run_frame($urandom_range(20, 40));
    end
  endtask

  task automatic test_steady_stream();
    drain_results();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    set_grid(8'd6, 8'd6);
    run_frame(40);
    drain_results();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_output_stall();
    set_grid(8'd4, 8'd10);
    sender_idles = 1'b0;
    hold_req = !hold_req;
    repeat (30)
      offer_item(MODE_UPDATE, X_W'($urandom_range(0, 3)), Y_W'($urandom_range(0, 9)),
                 kind_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    offer_item(MODE_EOF, 7'd0, 7'd0, KIND_SAND, 1'b0);
    sender_idles = 1'b1;
    drain_results();
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_moves();
    test_dimension_limits();
    test_random_frames(250);
    test_steady_stream();
    test_output_stall();
    test_random_frames(550);
    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d items (%0d frame sweeps) over %0d register writes,",
             items_sent, sweeps, reg_writes);
    $display("with %0d results checked and %0d mismatches.", moves_checked, mismatches);
    if (mismatches == 0 && expected_moves.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
